FILE: rtl/core/wpsm_pkg.sv
package wpsm_pkg;

   // Field widths fixed by the item formats
   localparam int CNT_W     = 7;
   localparam int SLOT_ID_W = 6;
   localparam int TIME_W    = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;

   // Spawn results above this batch size raise the busy warning
   localparam int BUSY_BATCH = 8;

   // Configuration register reset values
   localparam logic [CNT_W-1:0]  ACTIVE_SLOTS_RST = 7'd64;
   localparam logic [CNT_W-1:0]  MAX_SPARE_RST    = 7'd10;
   localparam logic [CNT_W-1:0]  MIN_SPARE_RST    = 7'd5;
   localparam logic [TIME_W-1:0] IDLE_TIMEOUT_RST = 32'd600000;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_SLOTS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPARE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SPARE    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_TIMEOUT = 2'd3;

   // Item operation codes
   localparam logic OP_REPORT = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   typedef enum logic [1:0] {
      STAT_DEAD     = 2'd0,
      STAT_STARTING = 2'd1,
      STAT_READY    = 2'd2,
      STAT_BUSY     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_SPAWN = 2'd1,
      ACT_KILL  = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_SPAWN
   } state_type;

   typedef struct packed {
      logic                 op;
      logic [SLOT_ID_W-1:0] report_slot;
      logic [1:0]           new_status;
      logic [TIME_W-1:0]    now;
   } req_type;

   typedef struct packed {
      action_type           action;
      logic [SLOT_ID_W-1:0] target_slot;
      logic [CNT_W-1:0]     idle_total;
      logic                 busy_warning;
      logic                 full_warning;
      logic                 last;
   } rsp_type;

endpackage

FILE: rtl/core/worker_pool_spare_manager_core.sv
// Spare worker pool manager.
// Request channel: an item is taken at a clock edge with start high and busy
// low. A status report (op 0) writes one slot's status; a maintenance tick
// (op 1) scans the active slots and decides on a kill, a spawn batch or none.
// Result channel: each result sits on rsp_data for exactly one cycle while
// rsp_strobe is high; the receiver cannot stall, so no result is held back.
// The last result of an item carries last = 1.
// Configuration channel: csr_valid/csr_ready with csr_index and csr_data;
// csr_ready is always high and writes are meant for idle periods.
// Flow: a report gives its single result in the cycle after it is taken and
// the block is ready again at once. A tick reads n slots, n at most
// min(active_slots, SLOT_COUNT), one per cycle through the single read port
// of the status memory; the scan stops early once a full batch of free slots
// is gathered at or above the high-water mark. The scan is followed by the
// decision state; a kill, no-action or full-warning result follows in the
// next cycle. A spawn decision gives one result per cycle from the free list
// until the gathered batch is out, with busy high throughout.
// Reset: a clearing pass writes every status entry to dead with busy high;
// configuration writes are taken meanwhile.
module worker_pool_spare_manager_core #(
   parameter int SLOT_COUNT = 64,
   parameter int MAX_BATCH  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  wpsm_pkg::req_type                   req_data,
   output logic                                rsp_strobe,
   output wpsm_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wpsm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wpsm_pkg::CSR_DAT_W-1:0]      csr_data
);
   import wpsm_pkg::*;

   localparam int SLOT_W  = $clog2(SLOT_COUNT);
   localparam int BATCH_W = $clog2(MAX_BATCH + 1);
   localparam int FREE_AW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
   localparam logic [SLOT_W-1:0]  CLR_LAST  = SLOT_W'(SLOT_COUNT - 1);
   localparam logic [BATCH_W-1:0] BATCH_MAX = BATCH_W'(MAX_BATCH);
   localparam logic [BATCH_W:0]   BATCH_MAX_X = (BATCH_W + 1)'(MAX_BATCH);

   // Configuration registers
   logic [CNT_W-1:0]  active_slots_ff;
   logic [CNT_W-1:0]  max_spare_ff;
   logic [CNT_W-1:0]  min_spare_ff;
   logic [TIME_W-1:0] idle_timeout_ff;

   // Sequencer and pool state
   state_type          state_ff, state_in;
   logic [SLOT_W-1:0]  clr_idx_ff, clr_idx_in;
   logic [CNT_W-1:0]   high_water_ff, high_water_in;
   logic [BATCH_W-1:0] batch_ff, batch_in;
   logic [TIME_W-1:0]  last_change_ff, last_change_in;

   // Tick working registers
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [CNT_W-1:0]   limit_ff, limit_in;
   logic [CNT_W-1:0]   scan_idx_ff, scan_idx_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [CNT_W-1:0]   pend_idx_ff, pend_idx_in;
   logic [CNT_W-1:0]   idle_ff, idle_in;
   logic [BATCH_W-1:0] nfree_ff, nfree_in;
   logic               have_ready_ff, have_ready_in;
   logic [CNT_W-1:0]   ready_slot_ff, ready_slot_in;
   logic [CNT_W-1:0]   top_ff, top_in;
   logic [BATCH_W-1:0] spawn_idx_ff, spawn_idx_in;
   logic               busy_flag_ff, busy_flag_in;

   // Result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // Status memory and free list
   logic [1:0]        slot_mem [SLOT_COUNT];
   logic [1:0]        mem_rd_ff;
   logic              mem_we;
   logic [SLOT_W-1:0] mem_waddr;
   logic [1:0]        mem_wdata;
   logic [SLOT_W-1:0] mem_raddr;

   logic [CNT_W-1:0]   free_mem [MAX_BATCH];
   logic [CNT_W-1:0]   fl_rd_ff;
   logic               fl_we;
   logic [FREE_AW-1:0] fl_waddr;
   logic [CNT_W-1:0]   fl_wdata;
   logic [FREE_AW-1:0] fl_raddr;

   // Decision terms
   logic              scan_brk, scan_end;
   logic              idle_hi, idle_lo, no_free, timed_out, do_spawn, spawn_last;
   logic [TIME_W-1:0] elapsed;
   logic [BATCH_W:0]  batch_dbl;
   logic [CNT_W-1:0]  spawn_top;

   assign busy       = (state_ff != S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign scan_brk   = pend_valid_ff && (pend_idx_ff >= high_water_ff) && (nfree_ff == batch_ff);
   assign scan_end   = scan_brk || (!pend_valid_ff && (scan_idx_ff >= limit_ff));
   assign idle_hi    = idle_ff > max_spare_ff;
   assign idle_lo    = idle_ff < min_spare_ff;
   assign no_free    = (nfree_ff == '0);
   assign elapsed    = now_ff - last_change_ff;
   assign timed_out  = elapsed > idle_timeout_ff;
   assign do_spawn   = !idle_hi && idle_lo && !no_free;
   assign spawn_last = (BATCH_W'(spawn_idx_ff + 1'b1) == nfree_ff);
   assign batch_dbl  = {batch_ff, 1'b0};
   assign spawn_top  = fl_rd_ff + 7'd1;
   assign mem_raddr  = SLOT_W'(scan_idx_ff);

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_slots_ff <= ACTIVE_SLOTS_RST;
         max_spare_ff    <= MAX_SPARE_RST;
         min_spare_ff    <= MIN_SPARE_RST;
         idle_timeout_ff <= IDLE_TIMEOUT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ACTIVE_SLOTS: active_slots_ff <= csr_data[CNT_W-1:0];
            CSR_MAX_SPARE:    max_spare_ff    <= csr_data[CNT_W-1:0];
            CSR_MIN_SPARE:    min_spare_ff    <= csr_data[CNT_W-1:0];
            CSR_IDLE_TIMEOUT: idle_timeout_ff <= csr_data[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR:  if (clr_idx_ff == CLR_LAST) state_in = S_IDLE;
         S_IDLE:   if (start && req_data.op == OP_TICK) state_in = S_SCAN;
         S_SCAN:   if (scan_end) state_in = S_DECIDE;
         S_DECIDE: state_in = do_spawn ? S_SPAWN : S_IDLE;
         S_SPAWN:  if (spawn_last) state_in = S_IDLE;
         default:  state_in = S_CLEAR;
      endcase
   end

   // Datapath and result control
   always_comb begin
      clr_idx_in     = clr_idx_ff;
      high_water_in  = high_water_ff;
      batch_in       = batch_ff;
      last_change_in = last_change_ff;
      now_in         = now_ff;
      limit_in       = limit_ff;
      scan_idx_in    = scan_idx_ff;
      pend_valid_in  = 1'b0;
      pend_idx_in    = pend_idx_ff;
      idle_in        = idle_ff;
      nfree_in       = nfree_ff;
      have_ready_in  = have_ready_ff;
      ready_slot_in  = ready_slot_ff;
      top_in         = top_ff;
      spawn_idx_in   = spawn_idx_ff;
      busy_flag_in   = busy_flag_ff;
      rsp_valid_in   = 1'b0;
      rsp_data_in.action       = ACT_NONE;
      rsp_data_in.target_slot  = '0;
      rsp_data_in.idle_total   = idle_ff;
      rsp_data_in.busy_warning = 1'b0;
      rsp_data_in.full_warning = 1'b0;
      rsp_data_in.last         = 1'b1;
      mem_we    = 1'b0;
      mem_waddr = clr_idx_ff;
      mem_wdata = STAT_DEAD;
      fl_we     = 1'b0;
      fl_waddr  = FREE_AW'(nfree_ff);
      fl_wdata  = pend_idx_ff;
      fl_raddr  = '0;

      case (state_ff)
         // Sweep the status memory to dead
         S_CLEAR: begin
            mem_we     = 1'b1;
            clr_idx_in = clr_idx_ff + 1'b1;
         end

         // Take a report or start a tick
         S_IDLE: begin
            if (start) begin
               if (req_data.op == OP_REPORT) begin
                  mem_we    = (32'(req_data.report_slot) < SLOT_COUNT);
                  mem_waddr = SLOT_W'(req_data.report_slot);
                  mem_wdata = req_data.new_status;
                  rsp_valid_in = 1'b1;
                  rsp_data_in.idle_total = '0;
               end else begin
                  now_in        = req_data.now;
                  limit_in      = (32'(active_slots_ff) < SLOT_COUNT) ?
                                  active_slots_ff : CNT_W'(SLOT_COUNT);
                  scan_idx_in   = '0;
                  idle_in       = '0;
                  nfree_in      = '0;
                  have_ready_in = 1'b0;
                  ready_slot_in = '0;
                  top_in        = '0;
               end
            end
         end

         // Issue one slot read per cycle, evaluate the slot read last cycle
         S_SCAN: begin
            if (!scan_end && scan_idx_ff < limit_ff) begin
               pend_valid_in = 1'b1;
               pend_idx_in   = scan_idx_ff;
               scan_idx_in   = scan_idx_ff + 1'b1;
            end
            if (pend_valid_ff && !scan_brk) begin
               case (status_type'(mem_rd_ff))
                  STAT_DEAD: begin
                     if (nfree_ff < batch_ff && nfree_ff < BATCH_MAX) begin
                        fl_we    = 1'b1;
                        nfree_in = nfree_ff + 1'b1;
                     end
                  end
                  STAT_STARTING: begin
                     idle_in = idle_ff + 1'b1;
                     top_in  = pend_idx_ff + 1'b1;
                  end
                  STAT_READY: begin
                     idle_in       = idle_ff + 1'b1;
                     have_ready_in = 1'b1;
                     ready_slot_in = pend_idx_ff;
                     top_in        = pend_idx_ff + 1'b1;
                  end
                  default: top_in = pend_idx_ff + 1'b1;
               endcase
            end
         end

         // Pick kill, spawn batch or nothing
         S_DECIDE: begin
            high_water_in = top_ff;
            if (idle_hi) begin
               batch_in     = BATCH_W'(1);
               rsp_valid_in = 1'b1;
               if (have_ready_ff) begin
                  last_change_in          = now_ff;
                  rsp_data_in.action      = ACT_KILL;
                  rsp_data_in.target_slot = ready_slot_ff[SLOT_ID_W-1:0];
               end
            end else if (idle_lo) begin
               if (no_free) begin
                  rsp_valid_in             = 1'b1;
                  rsp_data_in.full_warning = 1'b1;
               end else begin
                  fl_raddr       = '0;
                  spawn_idx_in   = '0;
                  busy_flag_in   = (32'(batch_ff) > BUSY_BATCH);
                  last_change_in = now_ff;
                  if (batch_ff < BATCH_MAX) begin
                     batch_in = (batch_dbl > BATCH_MAX_X) ? BATCH_MAX :
                                batch_dbl[BATCH_W-1:0];
                  end
               end
            end else begin
               batch_in     = BATCH_W'(1);
               rsp_valid_in = 1'b1;
               if (idle_ff > min_spare_ff && timed_out && have_ready_ff) begin
                  last_change_in          = now_ff;
                  rsp_data_in.action      = ACT_KILL;
                  rsp_data_in.target_slot = ready_slot_ff[SLOT_ID_W-1:0];
               end
            end
         end

         // Emit one spawn per cycle from the free list
         S_SPAWN: begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.action       = ACT_SPAWN;
            rsp_data_in.target_slot  = fl_rd_ff[SLOT_ID_W-1:0];
            rsp_data_in.busy_warning = busy_flag_ff;
            rsp_data_in.last         = spawn_last;
            if (spawn_top > high_water_ff) high_water_in = spawn_top;
            spawn_idx_in = spawn_idx_ff + 1'b1;
            fl_raddr     = spawn_last ? '0 : FREE_AW'(spawn_idx_ff + 1'b1);
         end

         default: ;
      endcase
   end

   // Hold control and pool state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_idx_ff     <= '0;
         high_water_ff  <= '0;
         batch_ff       <= BATCH_W'(1);
         last_change_ff <= '0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_idx_ff     <= clr_idx_in;
         high_water_ff  <= high_water_in;
         batch_ff       <= batch_in;
         last_change_ff <= last_change_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Hold working payload
   always_ff @(posedge clock) begin
      now_ff        <= now_in;
      limit_ff      <= limit_in;
      scan_idx_ff   <= scan_idx_in;
      pend_idx_ff   <= pend_idx_in;
      idle_ff       <= idle_in;
      nfree_ff      <= nfree_in;
      have_ready_ff <= have_ready_in;
      ready_slot_ff <= ready_slot_in;
      top_ff        <= top_in;
      spawn_idx_ff  <= spawn_idx_in;
      busy_flag_ff  <= busy_flag_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // Status memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) slot_mem[mem_waddr] <= mem_wdata;
      mem_rd_ff <= slot_mem[mem_raddr];
   end

   // Free list memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (fl_we) free_mem[fl_waddr] <= fl_wdata;
      fl_rd_ff <= free_mem[fl_raddr];
   end

`ifndef ASSERT_OFF
   // No result leaves during the clearing pass
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !rsp_strobe)
      else $error("result strobe during clearing pass");

   // The free list never outgrows the batch while scanning
   a_nfree_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (nfree_ff <= batch_ff))
      else $error("free list larger than spawn batch");

   // Every spawn cycle yields a spawn result next cycle
   a_spawn_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SPAWN) |=> (rsp_strobe && rsp_data.action == ACT_SPAWN))
      else $error("spawn cycle without spawn result");

   // A report gives its single final result in the next cycle
   a_report_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.op == OP_REPORT) |=> (rsp_strobe && rsp_data.last))
      else $error("report without final result");

   // A result with no action names slot zero
   a_none_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.action == ACT_NONE) |-> (rsp_data.target_slot == '0))
      else $error("no-action result with nonzero slot");
`endif

endmodule
